// ===== sv/fpfa_pkg.sv =====
// Package for the fixed partition fit allocator.
// Holds command, status, policy, register and state codes and the fit unit structs.
// No dependencies.
package fpfa_pkg;

  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 6;
  localparam int unsigned SLOT_REACH = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_NOFIT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    POL_WORST = 2'd0,
    POL_BEST  = 2'd1,
    POL_FIRST = 2'd2
  } policy_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_BLOCKS = 2'd0,
    CFG_POLICY = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_RESULT = 2'd2
  } state_t;

  // Control from the sequencer to the fit unit.
  typedef struct packed {
    logic start;
    logic cand_valid;
    logic cand_taken;
  } fit_ctrl_t;

  // Running choice held by the fit unit.
  typedef struct packed {
    logic              found;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] left;
  } fit_res_t;

endpackage

// ===== sv/fpfa_if.sv =====
// Channel interfaces of the fixed partition fit allocator: input, result and configuration.
// Depends on fpfa_pkg for field widths.
interface fpfa_in_if import fpfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] slot;
  logic [SIZE_W-1:0] amount;

  modport source (output valid, cmd, slot, amount, input ready);
  modport sink   (input valid, cmd, slot, amount, output ready);
endinterface

interface fpfa_out_if import fpfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] chosen_slot;
  logic [SIZE_W-1:0] chosen_size;
  logic [SIZE_W-1:0] leftover;

  modport source (output valid, status, chosen_slot, chosen_size, leftover, input ready);
  modport sink   (input valid, status, chosen_slot, chosen_size, leftover, output ready);
endinterface

interface fpfa_cfg_if import fpfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] addr;
  logic [CFG_D_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== sv/fpfa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fpfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== sv/fpfa_fit_unit.sv =====
// Shared compare unit: judges one candidate partition per cycle and keeps the running choice.
// Depends on fpfa_pkg.
module fpfa_fit_unit import fpfa_pkg::*; #(
  parameter int unsigned IDX_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fit_ctrl_t         ctrl,
  input  logic [IDX_W-1:0]  cand_idx,
  input  logic [SIZE_W-1:0] cand_size,
  input  logic [SIZE_W-1:0] request,
  input  policy_t           policy,
  output fit_res_t          res,
  output logic [IDX_W-1:0]  pick
);
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  pick_r, pick_nxt;
  logic [SIZE_W-1:0] left_r, left_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              fits;
  logic              better;
  logic [SIZE_W-1:0] left;

  assign left = cand_size - request;
  assign fits = ctrl.cand_valid && !ctrl.cand_taken && (cand_size >= request);

  // Ties keep the earlier, lower index; first fit never replaces a choice.
  always_comb begin
    better = 1'b0;
    if (!found_r) begin
      better = 1'b1;
    end else if (policy == POL_WORST) begin
      better = left > left_r;
    end else if (policy == POL_BEST) begin
      better = left < left_r;
    end
  end

  always_comb begin
    found_nxt = found_r;
    pick_nxt  = pick_r;
    left_nxt  = left_r;
    size_nxt  = size_r;
    if (ctrl.start) begin
      found_nxt = 1'b0;
    end else if (fits && better) begin
      found_nxt = 1'b1;
      pick_nxt  = cand_idx;
      left_nxt  = left;
      size_nxt  = cand_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    pick_r <= pick_nxt;
    left_r <= left_nxt;
    size_r <= size_nxt;
  end

  assign res.found = found_r;
  assign res.size  = size_r;
  assign res.left  = left_r;
  assign pick      = pick_r;
endmodule

// ===== sv/fixed_partition_fit_allocator.sv =====
// Top level of the fixed partition fit allocator: sequencer, taken marks, output register.
// Depends on fpfa_pkg, fpfa_if, fpfa_ram and fpfa_fit_unit.
//
// Usage. Items arrive on in_chan (cmd, slot, amount) and each item yields exactly one
// result transfer on out_chan (status, chosen_slot, chosen_size, leftover). A load item
// writes a partition size and frees that partition; a clear item frees every partition;
// an allocate item scans the partitions in use and takes one by the configured policy
// (worst fit, best fit or first fit, lowest index on a tie).
// The cfg_chan port writes blocks_in_use (index 0) and fit_policy (index 1); it is always
// ready and must only be used while no item is outstanding.
// Sequence: a load, clear or unused command moves the sequencer from idle to the result
// state, and the result then enters the output register. An allocate first scans N
// partitions, where N is blocks_in_use limited to the table depth and to 32: the single
// compare unit examines one partition a cycle, fed by the size RAM's registered read
// port. The allocate then passes through the result state into the output register.
// Throughput: one item at a time; in_chan is ready only while the sequencer is idle.
// A finished result waits in the output register, and the next item may be taken while
// it waits. If the receiver stalls, a second result is held in the sequencer until the
// output register is free, and in_chan stays low meanwhile.
// Reset (rst_n, synchronous, active low) clears all taken marks, both registers and the
// handshake state. Partition sizes are not cleared and must be loaded before use.
module fixed_partition_fit_allocator import fpfa_pkg::*; #(
  parameter int unsigned MAX_PARTITIONS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  fpfa_in_if.sink    in_chan,
  fpfa_out_if.source out_chan,
  fpfa_cfg_if.sink   cfg_chan
);
  localparam int unsigned IDX_W    = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int unsigned SCAN_LIM =
      (MAX_PARTITIONS < SLOT_REACH) ? MAX_PARTITIONS : SLOT_REACH;
  localparam int unsigned CNT_W    = $clog2(SCAN_LIM + 1);

  // Configuration registers.
  logic [CFG_D_W-1:0] blocks_r;
  logic [1:0]         policy_r;

  // Sequencer state and the item being worked on.
  state_t             state_r, state_nxt;
  cmd_t               cmd_r;
  logic [SIZE_W-1:0]  amount_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rd_valid_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [MAX_PARTITIONS-1:0] taken_r, taken_nxt;

  // Output register.
  logic               out_valid_r;
  status_t            out_status_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [SIZE_W-1:0]  out_size_r;
  logic [SIZE_W-1:0]  out_left_r;

  logic               in_xfer;
  logic               slot_ok;
  logic [CNT_W-1:0]   scan_n;
  logic               issue;
  logic               scan_done;
  logic               out_free;
  logic               load_out;
  logic               ram_we;
  logic [SIZE_W-1:0]  ram_rdata;
  fit_ctrl_t          fit_ctrl;
  fit_res_t           fit_res;
  logic [IDX_W-1:0]   fit_pick;
  status_t            res_status;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign slot_ok  = (7'(in_chan.slot) < 7'(MAX_PARTITIONS));
  assign scan_n   = (blocks_r > CFG_D_W'(SCAN_LIM)) ? CNT_W'(SCAN_LIM) : CNT_W'(blocks_r);
  assign out_free = !out_valid_r || out_chan.ready;

  // Partition sizes live in a RAM; the scan reads one entry a cycle.
  fpfa_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (MAX_PARTITIONS)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_chan.slot)),
    .wdata (in_chan.amount),
    .re    (issue),
    .raddr (IDX_W'(cnt_r)),
    .rdata (ram_rdata)
  );

  fpfa_fit_unit #(
    .IDX_W (IDX_W)
  ) u_fit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (fit_ctrl),
    .cand_idx  (rd_idx_r),
    .cand_size (ram_rdata),
    .request   (amount_r),
    .policy    (policy_t'(policy_r)),
    .res       (fit_res),
    .pick      (fit_pick)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (cmd_t'(in_chan.cmd) == CMD_ALLOC) ? S_SCAN : S_RESULT;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_chan.ready       = 1'b0;
    ram_we              = 1'b0;
    issue               = 1'b0;
    scan_done           = 1'b0;
    load_out            = 1'b0;
    fit_ctrl.start      = 1'b0;
    fit_ctrl.cand_valid = rd_valid_r;
    fit_ctrl.cand_taken = taken_r[rd_idx_r];
    cnt_nxt             = cnt_r;
    taken_nxt           = taken_r;
    case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_xfer) begin
          case (cmd_t'(in_chan.cmd))
            CMD_LOAD: begin
              if (slot_ok) begin
                ram_we = 1'b1;
                taken_nxt[IDX_W'(in_chan.slot)] = 1'b0;
              end
            end
            CMD_CLEAR: taken_nxt = '0;
            CMD_ALLOC: begin
              fit_ctrl.start = 1'b1;
              cnt_nxt        = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        issue     = (cnt_r < scan_n);
        scan_done = !issue && !rd_valid_r;
        if (issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (scan_done && fit_res.found) begin
          taken_nxt[fit_pick] = 1'b1;
        end
      end
      S_RESULT: load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_r != CMD_ALLOC) begin
      res_status = ST_DONE;
    end else if (fit_res.found) begin
      res_status = ST_ALLOC;
    end else begin
      res_status = ST_NOFIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      blocks_r    <= '0;
      policy_r    <= '0;
      taken_r     <= '0;
      rd_valid_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      taken_r    <= taken_nxt;
      rd_valid_r <= issue;
      cnt_r      <= cnt_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_idx_t'(cfg_chan.addr))
          CFG_BLOCKS: blocks_r <= cfg_chan.data;
          CFG_POLICY: policy_r <= cfg_chan.data[1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r    <= cmd_t'(in_chan.cmd);
      amount_r <= in_chan.amount;
    end
    rd_idx_r <= IDX_W'(cnt_r);
    if (load_out) begin
      out_status_r <= res_status;
      out_slot_r   <= (res_status == ST_ALLOC) ? SLOT_W'(fit_pick) : '0;
      out_size_r   <= (res_status == ST_ALLOC) ? fit_res.size : '0;
      out_left_r   <= (res_status == ST_ALLOC) ? fit_res.left : '0;
    end
  end

  assign cfg_chan.ready       = 1'b1;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.chosen_slot = out_slot_r;
  assign out_chan.chosen_size = out_size_r;
  assign out_chan.leftover    = out_left_r;

`ifndef SYNTHESIS
  // The chosen partition is marked taken before its result is presented.
  a_pick_marked: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_RESULT && cmd_r == CMD_ALLOC && fit_res.found) |-> taken_r[fit_pick])
    else $error("allocated partition not marked taken");

  // An allocation never reports a leftover larger than the partition.
  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_status_r == ST_ALLOC) |-> (out_left_r <= out_size_r))
    else $error("leftover exceeds partition size");

  // Results other than an allocation carry zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_status_r != ST_ALLOC) |->
      (out_slot_r == '0 && out_size_r == '0 && out_left_r == '0))
    else $error("non-allocation result has nonzero fields");

  // The scan never reads past the partitions in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_SCAN) |-> (cnt_r <= scan_n))
    else $error("scan counter beyond partitions in use");

  // A pending result is never overwritten while the receiver stalls.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_chan.ready) |-> !load_out)
    else $error("output register overwritten while stalled");
`endif
endmodule
